@@ rtl/tef_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touchpad typing edge filter package
// Event codes, key codes, edge test and key classification for the filter.
// ----------------------------------------------------------------------------
package tef_pkg;

    localparam int XW      = 16;
    localparam int KEYW    = 9;
    localparam int CFG_IW  = 3;
    localparam int CNTW    = 5;

    typedef enum logic [2:0] {
        REQ_PAD_DOWN   = 3'd0,
        REQ_PAD_MOTION = 3'd1,
        REQ_PAD_UP     = 3'd2,
        REQ_BUTTON     = 3'd3,
        REQ_TAP        = 3'd4,
        REQ_POINTER    = 3'd5,
        REQ_KEY        = 3'd6,
        REQ_OTHER      = 3'd7
    } t_req_type;

    typedef enum logic [CFG_IW-1:0] {
        CFG_PAD_WIDTH    = 3'd0,
        CFG_EDGE_MOTION  = 3'd1,
        CFG_EDGE_BUTTON  = 3'd2,
        CFG_EDGE_TAP     = 3'd3,
        CFG_EDGE_RELEASE = 3'd4
    } t_cfg_index;

    localparam logic [XW-1:0] PAD_WIDTH_RST = 16'd1600;
    localparam logic [XW-1:0] EDGE_RST      = 16'd80;

    localparam logic signed [CNTW-1:0] MOD_MAX = 5'sd15;
    localparam logic signed [CNTW-1:0] MOD_MIN = -5'sd16;

    localparam logic [KEYW-1:0] KEY_ESC       = 9'd1;
    localparam logic [KEYW-1:0] KEY_TAB       = 9'd15;
    localparam logic [KEYW-1:0] KEY_LCTRL     = 9'd29;
    localparam logic [KEYW-1:0] KEY_LSHIFT    = 9'd42;
    localparam logic [KEYW-1:0] KEY_RSHIFT    = 9'd54;
    localparam logic [KEYW-1:0] KEY_KPASTERSK = 9'd55;
    localparam logic [KEYW-1:0] KEY_LALT      = 9'd56;
    localparam logic [KEYW-1:0] KEY_CAPS      = 9'd58;
    localparam logic [KEYW-1:0] KEY_F1        = 9'd59;
    localparam logic [KEYW-1:0] KEY_RCTRL     = 9'd97;
    localparam logic [KEYW-1:0] KEY_RALT      = 9'd100;
    localparam logic [KEYW-1:0] KEY_LMETA     = 9'd125;
    localparam logic [KEYW-1:0] KEY_RMETA     = 9'd126;
    localparam logic [KEYW-1:0] KEY_MENU      = 9'd127;
    localparam logic [KEYW-1:0] KEY_FN        = 9'h1d0;

    function automatic logic f_inside(logic [XW-1:0] x, logic [XW-1:0] e,
                                      logic [XW-1:0] w);
        logic signed [XW:0] hi;
        hi = $signed({1'b0, w}) - $signed({1'b0, e});
        return (x > e) && ($signed({1'b0, x}) < hi);
    endfunction

    function automatic logic f_is_modifier(logic [KEYW-1:0] k);
        return (k == KEY_LCTRL)  || (k == KEY_RCTRL)   || (k == KEY_LALT)   ||
               (k == KEY_RALT)   || (k == KEY_LSHIFT)  || (k == KEY_RSHIFT) ||
               (k == KEY_FN)     || (k == KEY_CAPS)    || (k == KEY_TAB)    ||
               (k == KEY_MENU)   || (k == KEY_RMETA)   || (k == KEY_LMETA);
    endfunction

    function automatic logic f_is_standalone(logic [KEYW-1:0] k);
        return !f_is_modifier(k) &&
               ((k == KEY_ESC) || (k == KEY_KPASTERSK) || (k >= KEY_F1));
    endfunction

endpackage

@@ rtl/tef_key_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key flag table
// One-bit-per-key memory with registered read, write-to-read forwarding and
// a clearing sweep after reset.
// ----------------------------------------------------------------------------
module tef_key_table #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic                     i_wr_data,
    output logic                     o_rd_flag,
    output logic                     o_busy
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic            mem [DEPTH];
    logic            r_rd_q;
    logic            r_fwd_hit;
    logic            r_fwd_val;
    logic            r_clr_busy;
    logic [AW-1:0]   r_clr_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            wr_data;

    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = 1'b0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_data = i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == LAST) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_q    <= mem[i_rd_addr];
            r_fwd_hit <= wr_en && (wr_addr == i_rd_addr);
            r_fwd_val <= wr_data;
        end
    end

    assign o_rd_flag = r_fwd_hit ? r_fwd_val : r_rd_q;
    assign o_busy    = r_clr_busy;

endmodule

@@ rtl/touchpad_typing_edge_filter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touchpad typing edge filter
// Marks touchpad events near the pad edges for suppression while typing.
// ----------------------------------------------------------------------------
// Input channel: one event per transaction on i_in_valid / o_in_stall.
// Output channel: one suppress flag per event on o_out_valid / i_out_stall,
// in event order.
// Configuration: pad width and the motion, button, tap and release edge
// widths written on i_cfg_valid / o_cfg_ready with i_cfg_index and
// i_cfg_data; ready is always high. Write only while no event is in flight.
// Pipeline: the event is registered in stage one and then in the output
// register. Throughput: one event per cycle while the output does not
// stall. Stage one holds the event and the key flag read from the table;
// it computes and commits state as it moves into the output register, so a
// key flag written by one event is forwarded to the next.
// Reset: valid, configuration and state registers return to their defaults
// and the key flag table is swept to zero with o_in_stall high.
// Output stall: the output register holds, stage one holds, and o_in_stall
// rises once stage one is full.
// ----------------------------------------------------------------------------
module touchpad_typing_edge_filter
    import tef_pkg::*;
#(
    parameter int KEY_TABLE_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_req_type,
    input  logic [XW-1:0]     i_x_pos,
    input  logic              i_is_palm,
    input  logic              i_is_pressed,
    input  logic [KEYW-1:0]   i_key_code,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_suppress,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [XW-1:0]     i_cfg_data
);

    localparam int AW = $clog2(KEY_TABLE_DEPTH);
    localparam logic [KEYW:0] DEPTH_K = (KEYW + 1)'(KEY_TABLE_DEPTH);

    logic [XW-1:0] r_pad_width, r_edge_motion, r_edge_button, r_edge_tap;
    logic [XW-1:0] r_edge_release;

    logic          r_motion_lock, r_button_lock, r_tap_lock;
    logic          n_motion_lock, n_button_lock, n_tap_lock;
    logic [XW-1:0] r_down_x, r_current_x, n_down_x, n_current_x;
    logic          r_button_latch, r_tap_latch, n_button_latch, n_tap_latch;
    logic signed [CNTW-1:0] r_mod_cnt, n_mod_cnt;

    logic            r_s1_valid;
    t_req_type       r_s1_type;
    logic [XW-1:0]   r_s1_x;
    logic            r_s1_palm;
    logic            r_s1_pressed;
    logic [KEYW-1:0] r_s1_key;
    logic            r_s1_in_range;

    logic r_out_valid;
    logic r_out_suppress;
    logic n_suppress;

    logic            accept;
    logic            s1_move;
    logic            in_range;
    logic            tbl_busy;
    logic            tbl_flag;
    logic            tbl_wr_en;
    logic            tbl_wr_data;
    logic            key_mod;
    logic            key_alone;
    logic            key_set;
    logic            key_flag;

    assign s1_move     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = tbl_busy || (r_s1_valid && !s1_move);
    assign accept      = i_in_valid && !o_in_stall;
    assign in_range    = {1'b0, i_key_code} < DEPTH_K;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_suppress  = r_out_suppress;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad_width    <= PAD_WIDTH_RST;
            r_edge_motion  <= EDGE_RST;
            r_edge_button  <= EDGE_RST;
            r_edge_tap     <= EDGE_RST;
            r_edge_release <= EDGE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PAD_WIDTH:    r_pad_width    <= i_cfg_data;
                CFG_EDGE_MOTION:  r_edge_motion  <= i_cfg_data;
                CFG_EDGE_BUTTON:  r_edge_button  <= i_cfg_data;
                CFG_EDGE_TAP:     r_edge_tap     <= i_cfg_data;
                CFG_EDGE_RELEASE: r_edge_release <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tef_key_table #(
        .DEPTH(KEY_TABLE_DEPTH)
    ) u_key_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept && in_range),
        .i_rd_addr (i_key_code[AW-1:0]),
        .i_wr_en   (tbl_wr_en),
        .i_wr_addr (r_s1_key[AW-1:0]),
        .i_wr_data (tbl_wr_data),
        .o_rd_flag (tbl_flag),
        .o_busy    (tbl_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_type     <= t_req_type'(i_req_type);
            r_s1_x        <= i_x_pos;
            r_s1_palm     <= i_is_palm;
            r_s1_pressed  <= i_is_pressed;
            r_s1_key      <= i_key_code;
            r_s1_in_range <= in_range;
        end
    end

    always_comb begin
        n_motion_lock  = r_motion_lock;
        n_button_lock  = r_button_lock;
        n_tap_lock     = r_tap_lock;
        n_down_x       = r_down_x;
        n_current_x    = r_current_x;
        n_button_latch = r_button_latch;
        n_tap_latch    = r_tap_latch;
        n_mod_cnt      = r_mod_cnt;
        n_suppress     = 1'b0;
        tbl_wr_en      = 1'b0;
        tbl_wr_data    = r_s1_pressed;
        key_mod        = f_is_modifier(r_s1_key);
        key_alone      = f_is_standalone(r_s1_key);
        key_set        = 1'b0;
        key_flag       = 1'b0;

        case (r_s1_type)
            REQ_PAD_DOWN: begin
                n_down_x    = r_s1_x;
                n_current_x = r_s1_x;
                if (f_inside(r_s1_x, r_edge_motion, r_pad_width)) begin
                    n_motion_lock = 1'b0;
                end
                if (f_inside(r_s1_x, r_edge_button, r_pad_width)) begin
                    n_button_lock = 1'b0;
                end
                if (f_inside(r_s1_x, r_edge_tap, r_pad_width)) begin
                    n_tap_lock = 1'b0;
                end
            end
            REQ_PAD_MOTION: begin
                n_current_x = r_s1_x;
                if (!r_s1_palm && f_inside(r_s1_x, r_edge_release, r_pad_width)) begin
                    n_motion_lock = 1'b0;
                end
                n_suppress = !r_s1_palm && n_motion_lock &&
                             !f_inside(r_down_x, r_edge_motion, r_pad_width);
            end
            REQ_BUTTON: begin
                if (r_s1_pressed) begin
                    if (r_button_lock &&
                        !f_inside(r_current_x, r_edge_button, r_pad_width)) begin
                        n_button_latch = 1'b1;
                        n_suppress     = 1'b1;
                    end
                end else if (r_button_latch) begin
                    n_button_latch = 1'b0;
                    n_suppress     = 1'b1;
                end
            end
            REQ_TAP: begin
                if (r_s1_pressed) begin
                    if (r_tap_lock && !f_inside(r_down_x, r_edge_tap, r_pad_width)) begin
                        n_tap_latch = 1'b1;
                        n_suppress  = 1'b1;
                    end
                end else if (r_tap_latch) begin
                    n_tap_latch = 1'b0;
                    n_suppress  = 1'b1;
                end
            end
            REQ_POINTER: begin
                n_suppress = r_motion_lock &&
                             !f_inside(r_down_x, r_edge_motion, r_pad_width);
            end
            REQ_KEY: begin
                if (!key_alone) begin
                    if (key_mod) begin
                        if (r_s1_pressed) begin
                            if (r_mod_cnt != MOD_MAX) begin
                                n_mod_cnt = r_mod_cnt + 5'sd1;
                            end
                        end else if (r_mod_cnt != MOD_MIN) begin
                            n_mod_cnt = r_mod_cnt - 5'sd1;
                        end
                    end
                    key_set  = r_s1_pressed && (n_mod_cnt > 5'sd0);
                    key_flag = r_s1_in_range && (key_set || tbl_flag);
                    if (!key_mod && !key_flag) begin
                        n_motion_lock = 1'b1;
                        n_button_lock = 1'b1;
                        n_tap_lock    = 1'b1;
                    end
                    tbl_wr_en = s1_move && r_s1_in_range && (key_set || !r_s1_pressed);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion_lock  <= 1'b0;
            r_button_lock  <= 1'b0;
            r_tap_lock     <= 1'b0;
            r_down_x       <= '0;
            r_current_x    <= '0;
            r_button_latch <= 1'b0;
            r_tap_latch    <= 1'b0;
            r_mod_cnt      <= '0;
        end else if (s1_move) begin
            r_motion_lock  <= n_motion_lock;
            r_button_lock  <= n_button_lock;
            r_tap_lock     <= n_tap_lock;
            r_down_x       <= n_down_x;
            r_current_x    <= n_current_x;
            r_button_latch <= n_button_latch;
            r_tap_latch    <= n_tap_latch;
            r_mod_cnt      <= n_mod_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_suppress <= n_suppress;
        end
    end

endmodule

@@ rtl/tef_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touchpad typing edge filter checker
// Port-level checks of the output handshake and of reset behavior.
// ----------------------------------------------------------------------------
module tef_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input logic o_suppress
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output transaction dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_suppress))
        else $error("stalled suppress flag changed");

    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input taken before key table sweep");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind touchpad_typing_edge_filter tef_checker u_tef_checker (.*);
